/* hw/rtl/qdc_pkg.sv */
// Shared types and constants for the charge-converter event word decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package qdc_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ValueW = 12;
  localparam int unsigned ChanW  = 13;
  localparam int unsigned BaseW  = 12;
  localparam int unsigned CountW = 6;
  localparam int unsigned OutDataW = 32;

  // Word field positions
  localparam int unsigned TypeLsb  = 24;
  localparam int unsigned CountLsb = 8;
  localparam int unsigned ChanLsb  = 17;
  localparam int unsigned RangeBit = 16;
  localparam int unsigned OflowBit = 12;

  localparam logic [2:0]        TypeHeader  = 3'd2;
  localparam logic [2:0]        TypeTrailer = 3'd4;
  localparam logic [ValueW-1:0] ValueSat    = 12'd4095;
  localparam logic [ChanW-1:0]  RangeOffset = 13'd16;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_TRAILER = 2'd2,
    KIND_ERROR   = 2'd3
  } result_kind_e;

  typedef struct packed {
    result_kind_e      kind;
    logic [ValueW-1:0] adc_value;
    logic [ChanW-1:0]  channel_index;
    logic              end_of_event;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/qdc_decode.sv */
// Event framing state and per-word decode logic.
// Depends on qdc_pkg; feeds qdc_out_reg.
`default_nettype none

module qdc_decode
  import qdc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [WordW-1:0]  word_i,
  input  wire logic              cfg_we_i,
  input  wire logic [BaseW-1:0]  cfg_wdata_i,
  output result_t                result_o
);

  logic              in_event_q, in_event_d;
  logic [CountW-1:0] words_left_q, words_left_d;
  logic [BaseW-1:0]  base_index_q;
  logic [2:0]        word_type;
  logic [ChanW-1:0]  chan_sum;

  assign word_type = word_i[TypeLsb +: 3];
  assign chan_sum  = ChanW'(word_i[ChanLsb +: 4]) + ChanW'(base_index_q)
                   + (word_i[RangeBit] ? '0 : RangeOffset);

  always_comb begin
    in_event_d   = in_event_q;
    words_left_d = words_left_q;
    result_o     = '{kind: KIND_ERROR, adc_value: '0, channel_index: '0,
                     end_of_event: 1'b1};
    if (!in_event_q) begin
      if (word_type == TypeHeader) begin
        in_event_d   = 1'b1;
        words_left_d = word_i[CountLsb +: CountW];
        result_o.kind         = KIND_HEADER;
        result_o.end_of_event = 1'b0;
      end
    end else if (words_left_q != '0) begin
      words_left_d           = words_left_q - CountW'(1);
      result_o.kind          = KIND_DATA;
      result_o.adc_value     = word_i[OflowBit] ? ValueSat : word_i[ValueW-1:0];
      result_o.channel_index = chan_sum;
      result_o.end_of_event  = 1'b0;
    end else begin
      // trailer closes the event whether or not it checks out
      in_event_d = 1'b0;
      if (word_type == TypeTrailer) begin
        result_o.kind = KIND_TRAILER;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_event_q   <= 1'b0;
      words_left_q <= '0;
      base_index_q <= '0;
    end else begin
      if (accept_i) begin
        in_event_q   <= in_event_d;
        words_left_q <= words_left_d;
      end
      if (cfg_we_i) begin
        base_index_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/qdc_out_reg.sv */
// Result register with stream handshake towards the consumer.
// Depends on qdc_pkg; holds one decoded result until it is taken.
`default_nettype none

module qdc_out_reg
  import qdc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t result_i,
  input  wire logic    tready_i,
  output logic         ready_o,
  output logic         tvalid_o,
  output result_t      result_o
);

  logic    valid_q;
  result_t result_q;

  // advance whenever the held request leaves or the register is empty
  assign ready_o  = !valid_q || tready_i;
  assign tvalid_o = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/qdc_event_word_decoder.sv */
// The result of an accepted word is registered and shown on the master side in the next cycle.
// Throughput: one word per cycle; s_axis_tready falls only while a result
// is held back by the consumer.
// Reset: asynchronous, active low; clears the framing state (awaiting header),
// the word count, base_index and the result valid flag. No clearing pass.
// Depends on qdc_pkg, qdc_decode and qdc_out_reg.
`default_nettype none

module qdc_event_word_decoder
  import qdc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [WordW-1:0]     s_axis_tdata,   // [31:0] data_word
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutDataW-1:0]       m_axis_tdata,   // [11:0] adc_value,
                                                    // [24:12] channel_index, zeros above
  output logic [1:0]                m_axis_tuser,   // [1:0] result_kind
  output logic                      m_axis_tlast,   // end_of_event
  input  wire logic                 cfg_we_i,
  input  wire logic [BaseW-1:0]     cfg_wdata_i     // base_index
);

  logic    accept;
  result_t dec_result;
  result_t out_result;

  assign accept = s_axis_tvalid && s_axis_tready;

  qdc_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .word_i      (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (dec_result)
  );

  qdc_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (dec_result),
    .tready_i (m_axis_tready),
    .ready_o  (s_axis_tready),
    .tvalid_o (m_axis_tvalid),
    .result_o (out_result)
  );

  assign m_axis_tdata = {(OutDataW - ValueW - ChanW)'(0), out_result.channel_index,
                         out_result.adc_value};
  assign m_axis_tuser = out_result.kind;
  assign m_axis_tlast = out_result.end_of_event;

endmodule

`default_nettype wire

/* hw/rtl/qdc_checker.sv */
// Port-level checks for qdc_event_word_decoder, attached by bind.
// Depends on qdc_pkg for the result kind codes.
`default_nettype none

module qdc_checker
  import qdc_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [OutDataW-1:0]  m_axis_tdata,
  input wire logic [1:0]           m_axis_tuser,
  input wire logic                 m_axis_tlast
);

  // every accepted request shows up as a result in the next cycle
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  // end of event only on trailer or error, never on header or data
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_TRAILER ||
                                        m_axis_tuser == KIND_ERROR)))
    else $error("tlast does not match result kind");

  // payload of non-data results is zero
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tdata == '0)
    else $error("non-data result carries payload");

  // held result stays put while the consumer stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind qdc_event_word_decoder qdc_checker u_qdc_checker (.*);

`default_nettype wire
